@@ src/dleetx_pkg.sv @@
// Shared types and constants for the DLE/ETX frame deframer.
// No dependencies; used by dleetx_parse and dle_etx_packet_deframer.
package dleetx_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int POS_W           = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_ON_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE       = 2'd2;

    localparam logic [7:0] RST_ESCAPE_BYTE = 8'd16;
    localparam logic [7:0] RST_END_BYTE    = 8'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_ID   = 3'd1,
        PH_DATA      = 3'd2,
        PH_AFTER_ESC = 3'd3,
        PH_COMPLETE  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_START = 3'd1,
        K_DATA  = 3'd2,
        K_END   = 3'd3,
        K_ABORT = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       value_byte;
        logic [POS_W-1:0] position;
        logic             take_stamp;
    } result_t;

    typedef struct packed {
        logic       stamp_on_start;
        logic [7:0] escape_byte;
        logic [7:0] end_byte;
    } cfg_t;

endpackage

@@ src/dle_etx_packet_deframer.sv @@
// DLE/ETX byte-stuffing deframer, top level.
// Each result is registered; one byte per cycle sustained while out_stall is low.
// The parse state updates at acceptance, so each byte depends only on the combinational parser.
// An output register plus a skid stage keep input open while one result waits.
// Reset (rst_n, async, active low): phase idle, count zero, registers at defaults, no results.
// Depends on dleetx_pkg and dleetx_parse.
module dle_etx_packet_deframer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dleetx_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dleetx_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [7:0]                        value_byte,
    output logic [dleetx_pkg::POS_W-1:0]      position,
    output logic                              take_stamp
);

    dleetx_pkg::cfg_t                 cfg_reg;
    dleetx_pkg::phase_t               phase_reg;
    dleetx_pkg::phase_t               phase_next;
    logic [dleetx_pkg::CNT_W-1:0]     count_reg;
    logic [dleetx_pkg::CNT_W-1:0]     count_next;
    dleetx_pkg::result_t              result;
    dleetx_pkg::result_t              out_reg;
    dleetx_pkg::result_t              skid_reg;
    logic                             out_valid_reg;
    logic                             skid_valid_reg;
    logic                             accept;
    logic                             pop;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign pop      = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stamp_on_start <= 1'b0;
            cfg_reg.escape_byte    <= dleetx_pkg::RST_ESCAPE_BYTE;
            cfg_reg.end_byte       <= dleetx_pkg::RST_END_BYTE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dleetx_pkg::CFG_STAMP_ON_START: cfg_reg.stamp_on_start <= cfg_data[0];
                dleetx_pkg::CFG_ESCAPE_BYTE:    cfg_reg.escape_byte    <= cfg_data[7:0];
                dleetx_pkg::CFG_END_BYTE:       cfg_reg.end_byte       <= cfg_data[7:0];
                default:                        ;
            endcase
        end
    end

    dleetx_parse u_parse
    (
        .cfg        (cfg_reg),
        .phase      (phase_reg),
        .count      (count_reg),
        .rx_byte    (rx_byte),
        .phase_next (phase_next),
        .count_next (count_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dleetx_pkg::PH_IDLE;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign value_byte = out_reg.value_byte;
    assign position   = out_reg.position;
    assign take_stamp = out_reg.take_stamp;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_wait_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dleetx_pkg::PH_WAIT_ID || phase_reg == dleetx_pkg::PH_IDLE) |->
        count_reg == '0)
        else $error("byte count not cleared outside a frame");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dleetx_pkg::CNT_W'(dleetx_pkg::MAX_FRAME_BYTES))
        else $error("byte count beyond frame limit");

    a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule

@@ src/dleetx_parse.sv @@
// Combinational byte parser: next phase, next byte count and the result for one byte.
// Depends on dleetx_pkg.
module dleetx_parse
(
    input  dleetx_pkg::cfg_t                 cfg,
    input  dleetx_pkg::phase_t               phase,
    input  logic [dleetx_pkg::CNT_W-1:0]     count,
    input  logic [7:0]                       rx_byte,
    output dleetx_pkg::phase_t               phase_next,
    output logic [dleetx_pkg::CNT_W-1:0]     count_next,
    output dleetx_pkg::result_t              result
);

    logic is_esc;
    logic is_end;
    logic full;
    logic enter_wait;
    logic store;

    assign is_esc = (rx_byte == cfg.escape_byte);
    assign is_end = (rx_byte == cfg.end_byte);
    assign full   = (count >= dleetx_pkg::CNT_W'(dleetx_pkg::MAX_FRAME_BYTES));

    always_comb
    begin
        phase_next = phase;
        count_next = count;
        result     = '{kind: dleetx_pkg::K_NONE, value_byte: 8'd0,
                       position: '0, take_stamp: 1'b0};
        enter_wait = 1'b0;
        store      = 1'b0;

        unique case (phase)
            dleetx_pkg::PH_WAIT_ID:
            begin
                count_next = '0;
                if (rx_byte == 8'd0 || is_esc || is_end)
                begin
                    phase_next = dleetx_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next        = dleetx_pkg::PH_DATA;
                    result.kind       = dleetx_pkg::K_START;
                    result.value_byte = rx_byte;
                end
            end
            dleetx_pkg::PH_DATA:
            begin
                if (is_esc)
                    phase_next = dleetx_pkg::PH_AFTER_ESC;
                else
                    store = 1'b1;
            end
            dleetx_pkg::PH_AFTER_ESC:
            begin
                // escape checked first: when ESC equals ETX no END result is produced
                if (is_esc)
                begin
                    store = 1'b1;
                end
                else if (is_end)
                begin
                    phase_next      = dleetx_pkg::PH_COMPLETE;
                    result.kind     = dleetx_pkg::K_END;
                    result.position = dleetx_pkg::POS_W'(count);
                end
                else
                begin
                    result.kind = dleetx_pkg::K_ABORT;
                    enter_wait  = 1'b1;
                end
            end
            default:
            begin
                if (is_esc)
                begin
                    enter_wait = 1'b1;
                end
                else
                begin
                    phase_next = dleetx_pkg::PH_IDLE;
                    count_next = '0;
                end
            end
        endcase

        if (store)
        begin
            if (full)
            begin
                phase_next  = dleetx_pkg::PH_IDLE;
                count_next  = '0;
                result.kind = dleetx_pkg::K_ABORT;
            end
            else
            begin
                phase_next        = dleetx_pkg::PH_DATA;
                count_next        = count + 1'b1;
                result.kind       = dleetx_pkg::K_DATA;
                result.value_byte = rx_byte;
                result.position   = dleetx_pkg::POS_W'(count);
            end
        end

        if (enter_wait)
        begin
            phase_next        = dleetx_pkg::PH_WAIT_ID;
            count_next        = '0;
            result.take_stamp = cfg.stamp_on_start;
        end
    end

endmodule
